// ----- src/pklft_pkg.sv -----
// Shared types, constants and helper functions of the per-key LED fade trail.
// Used by every module of the block but pklft_ram; depends on nothing else.
package pklft_pkg;

  // Number of keys and the width of a key index.
  localparam int NUM_KEYS = 64;
  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // Field widths fixed by the interface.
  localparam int KEY_IDX_W = 6;
  localparam int LEVEL_W = 8;
  localparam int COLOR_W = 8;
  localparam int STEP_W = 16;

  // Configuration port geometry.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Fade levels and decay thresholds.
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hff;
  localparam logic [LEVEL_W-1:0] SLOW_LIMIT = 8'hf0;
  localparam logic [LEVEL_W-1:0] MID_LIMIT = 8'h40;
  localparam logic [LEVEL_W-1:0] LOW_LIMIT = 8'd32;
  localparam logic [LEVEL_W-1:0] MID_DECAY = 8'd16;
  localparam logic [LEVEL_W-1:0] LOW_DECAY = 8'd32;

  // Reset values of the configuration registers.
  localparam logic [STEP_W-1:0] FADE_INTERVAL_RESET = 16'd50;
  localparam logic [COLOR_W-1:0] HIGHLIGHT_RESET = 8'd255;
  localparam logic [COLOR_W-1:0] INACTIVE_RESET = 8'd0;

  // Bit-serial multiplier: one multiplier bit per cycle.
  localparam int MUL_STEPS = LEVEL_W;
  localparam int CNT_W = $clog2(MUL_STEPS);

  // Request codes.
  localparam logic REQ_KEY = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_FADE_INTERVAL   = 3'd0,
    REG_HIGHLIGHT_RED   = 3'd1,
    REG_HIGHLIGHT_GREEN = 3'd2,
    REG_HIGHLIGHT_BLUE  = 3'd3,
    REG_INACTIVE_RED    = 3'd4,
    REG_INACTIVE_GREEN  = 3'd5,
    REG_INACTIVE_BLUE   = 3'd6,
    REG_ENABLED         = 3'd7
  } reg_idx_t;

  // Input transaction payload.
  typedef struct packed {
    logic                 req_type;
    logic [KEY_IDX_W-1:0] key_index;
    logic                 key_pressed;
  } cmd_t;

  // Output transaction payload.
  typedef struct packed {
    logic [KEY_IDX_W-1:0] led_index;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 last_of_frame;
  } led_t;

  // Write request into the level store.
  typedef struct packed {
    logic               en;
    logic [KEY_W-1:0]   addr;
    logic [LEVEL_W-1:0] data;
  } lvl_wr_t;

  // Control of the serial multiplier lanes.
  typedef struct packed {
    logic start;
    logic shift;
  } mul_ctrl_t;

  // Level after one fade step.
  function automatic logic [LEVEL_W-1:0] decay_level(input logic [LEVEL_W-1:0] level);
    logic [LEVEL_W-1:0] result;
    if (level >= SLOW_LIMIT) begin
      result = level - 8'd1;
    end else if (level >= MID_LIMIT) begin
      result = level - MID_DECAY;
    end else if (level >= LOW_LIMIT) begin
      result = level - LOW_DECAY;
    end else begin
      result = '0;
    end
    return result;
  endfunction

endpackage

// ----- src/pklft_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
module pklft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/pklft_level_store.sv -----
// Fade level store: one RAM entry per key plus a valid bit per key cleared at reset.
// Depends on pklft_pkg and pklft_ram.
module pklft_level_store (
  input  logic                           clk,
  input  logic                           rst,
  input  pklft_pkg::lvl_wr_t             wr,
  input  logic                           rd_en,
  input  logic [pklft_pkg::KEY_W-1:0]    rd_addr,
  output logic [pklft_pkg::LEVEL_W-1:0]  rd_data
);

  logic [pklft_pkg::NUM_KEYS-1:0] valid;
  logic                           rd_valid;
  logic [pklft_pkg::LEVEL_W-1:0]  ram_q;

  pklft_ram #(
    .WIDTH(pklft_pkg::LEVEL_W),
    .DEPTH(pklft_pkg::NUM_KEYS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr.en),
    .wr_addr(wr.addr),
    .wr_data(wr.data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  // Valid bits: an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? ram_q : '0;

endmodule

// ----- src/pklft_mul_lane.sv -----
// One colour lane: bit-serial level times component, then division by 255.
// Depends on pklft_pkg.
module pklft_mul_lane (
  input  logic                           clk,
  input  pklft_pkg::mul_ctrl_t           ctrl,
  input  logic [pklft_pkg::LEVEL_W-1:0]  level,
  input  logic [pklft_pkg::COLOR_W-1:0]  comp,
  output logic [pklft_pkg::COLOR_W-1:0]  quot
);

  // The low half starts as the multiplier and fills with product bits.
  logic [pklft_pkg::COLOR_W-1:0] acc_hi;
  logic [pklft_pkg::LEVEL_W-1:0] acc_lo;
  logic [pklft_pkg::COLOR_W:0]   partial;
  logic [15:0]                   product;
  logic [16:0]                   rounded;

  // Add the component when the current multiplier bit is set.
  assign partial = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, comp} : '0);

  // Shift-add, one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc_hi <= '0;
      acc_lo <= level;
    end else if (ctrl.shift) begin
      acc_hi <= partial[pklft_pkg::COLOR_W:1];
      acc_lo <= {partial[0], acc_lo[pklft_pkg::LEVEL_W-1:1]};
    end
  end

  // Exact floor division by 255 for a product of two 8-bit values.
  assign product = {acc_hi, acc_lo};
  assign rounded = {1'b0, product} + {9'd0, product[15:8]} + 17'd1;
  assign quot = rounded[15:8];

endmodule

// ----- src/per_key_led_fade_trail.sv -----
// Per-key LED fade trail, top level.
// Command channel (cmd_valid/cmd_ready/cmd) takes key events and millisecond
// ticks; LED channel (led_valid/led_ready/led) gives one colour per key.
// While enabled, a key press sets that key's level to full in the cycle it is accepted.
// A tick advances the saturating elapsed counter; when it reaches
// fade_interval while enabled, the block walks keys 0 upward and sends one
// LED transaction per key, the last one flagged with last_of_frame.
// Each key passes through a RAM read, a load step, the bit-serial multiplier
// (one level bit per cycle, three colour lanes in parallel), the /255 step
// and an output state in which the result is offered and held while
// led_ready stays low.
// cmd_ready is high only while no step is running; events and non-stepping
// ticks leave the block idle. When the receiver stalls, the current result is
// held in the output register and the walk waits.
// Reset (rst, synchronous) loads register defaults, clears elapsed time and
// marks every level as zero at once through per-key valid bits.
// The APB port writes registers at byte address 4*index, no wait states.
module per_key_led_fade_trail (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  pklft_pkg::cmd_t               cmd,
  output logic                          led_valid,
  input  logic                          led_ready,
  output pklft_pkg::led_t               led,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pklft_pkg::ADDR_W-1:0]  paddr,
  input  logic [pklft_pkg::DATA_W-1:0]  pwdata,
  output logic [pklft_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [pklft_pkg::STEP_W-1:0]  fade_interval;
  logic [pklft_pkg::COLOR_W-1:0] highlight_red;
  logic [pklft_pkg::COLOR_W-1:0] highlight_green;
  logic [pklft_pkg::COLOR_W-1:0] highlight_blue;
  logic [pklft_pkg::COLOR_W-1:0] inactive_red;
  logic [pklft_pkg::COLOR_W-1:0] inactive_green;
  logic [pklft_pkg::COLOR_W-1:0] inactive_blue;
  logic                          enabled;

  // Walk state.
  logic [pklft_pkg::STEP_W-1:0]  elapsed_ms;
  logic [pklft_pkg::STEP_W-1:0]  elapsed_next;
  logic [pklft_pkg::KEY_W-1:0]   key;
  logic [pklft_pkg::CNT_W-1:0]   cnt;
  logic                          lit;
  logic                          last_key;

  // Datapath links.
  logic                          cfg_write;
  pklft_pkg::reg_idx_t           reg_idx;
  pklft_pkg::lvl_wr_t            lvl_wr;
  logic                          lvl_rd_en;
  logic [pklft_pkg::LEVEL_W-1:0] lvl_rd;
  logic [pklft_pkg::LEVEL_W-1:0] lvl_decayed;
  pklft_pkg::mul_ctrl_t          mul_ctrl;
  logic [pklft_pkg::COLOR_W-1:0] quot_red;
  logic [pklft_pkg::COLOR_W-1:0] quot_green;
  logic [pklft_pkg::COLOR_W-1:0] quot_blue;
  logic                          cmd_take;
  logic                          press_ok;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx = pklft_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_interval <= pklft_pkg::FADE_INTERVAL_RESET;
      highlight_red <= pklft_pkg::HIGHLIGHT_RESET;
      highlight_green <= pklft_pkg::HIGHLIGHT_RESET;
      highlight_blue <= pklft_pkg::HIGHLIGHT_RESET;
      inactive_red <= pklft_pkg::INACTIVE_RESET;
      inactive_green <= pklft_pkg::INACTIVE_RESET;
      inactive_blue <= pklft_pkg::INACTIVE_RESET;
      enabled <= 1'b1;
    end else if (cfg_write) begin
      unique case (reg_idx)
        pklft_pkg::REG_FADE_INTERVAL:   fade_interval <= pwdata[15:0];
        pklft_pkg::REG_HIGHLIGHT_RED:   highlight_red <= pwdata[7:0];
        pklft_pkg::REG_HIGHLIGHT_GREEN: highlight_green <= pwdata[7:0];
        pklft_pkg::REG_HIGHLIGHT_BLUE:  highlight_blue <= pwdata[7:0];
        pklft_pkg::REG_INACTIVE_RED:    inactive_red <= pwdata[7:0];
        pklft_pkg::REG_INACTIVE_GREEN:  inactive_green <= pwdata[7:0];
        pklft_pkg::REG_INACTIVE_BLUE:   inactive_blue <= pwdata[7:0];
        pklft_pkg::REG_ENABLED:         enabled <= pwdata[0];
        default:                        enabled <= enabled;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      pklft_pkg::REG_FADE_INTERVAL:   prdata = 32'(fade_interval);
      pklft_pkg::REG_HIGHLIGHT_RED:   prdata = 32'(highlight_red);
      pklft_pkg::REG_HIGHLIGHT_GREEN: prdata = 32'(highlight_green);
      pklft_pkg::REG_HIGHLIGHT_BLUE:  prdata = 32'(highlight_blue);
      pklft_pkg::REG_INACTIVE_RED:    prdata = 32'(inactive_red);
      pklft_pkg::REG_INACTIVE_GREEN:  prdata = 32'(inactive_green);
      pklft_pkg::REG_INACTIVE_BLUE:   prdata = 32'(inactive_blue);
      pklft_pkg::REG_ENABLED:         prdata = 32'(enabled);
      default:                        prdata = '0;
    endcase
  end

  // Command handshake and decode.
  assign cmd_ready = (state == ST_IDLE);
  assign cmd_take = cmd_valid && cmd_ready;
  assign press_ok = enabled && cmd.key_pressed &&
                    (32'(cmd.key_index) < 32'(pklft_pkg::NUM_KEYS));
  assign elapsed_next = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + 16'd1;
  assign last_key = (key == pklft_pkg::KEY_W'(pklft_pkg::NUM_KEYS - 1));

  // Level store access: presses in idle, decayed write-back during the walk.
  assign lvl_decayed = pklft_pkg::decay_level(lvl_rd);
  assign lvl_rd_en = (state == ST_READ);

  always_comb begin
    lvl_wr = '0;
    if (state == ST_LOAD) begin
      lvl_wr.en = 1'b1;
      lvl_wr.addr = key;
      lvl_wr.data = lvl_decayed;
    end else if (cmd_take && (cmd.req_type == pklft_pkg::REQ_KEY) && press_ok) begin
      lvl_wr.en = 1'b1;
      lvl_wr.addr = pklft_pkg::KEY_W'(cmd.key_index);
      lvl_wr.data = pklft_pkg::FULL_LEVEL;
    end
  end

  pklft_level_store u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (lvl_wr),
    .rd_en  (lvl_rd_en),
    .rd_addr(key),
    .rd_data(lvl_rd)
  );

  // Three colour lanes share one multiplier sequence.
  assign mul_ctrl.start = (state == ST_LOAD);
  assign mul_ctrl.shift = (state == ST_MUL);

  pklft_mul_lane u_lane_red (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .level(lvl_rd),
    .comp (highlight_red),
    .quot (quot_red)
  );

  pklft_mul_lane u_lane_green (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .level(lvl_rd),
    .comp (highlight_green),
    .quot (quot_green)
  );

  pklft_mul_lane u_lane_blue (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .level(lvl_rd),
    .comp (highlight_blue),
    .quot (quot_blue)
  );

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      elapsed_ms <= '0;
      key <= '0;
      cnt <= '0;
      lit <= 1'b0;
      led_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_take && (cmd.req_type == pklft_pkg::REQ_TICK)) begin
            if (enabled && (elapsed_next >= fade_interval)) begin
              elapsed_ms <= '0;
              key <= '0;
              state <= ST_READ;
            end else begin
              elapsed_ms <= elapsed_next;
            end
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          lit <= (lvl_rd != '0) && (lvl_decayed != '0);
          cnt <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (cnt == pklft_pkg::CNT_W'(pklft_pkg::MUL_STEPS - 1)) begin
            state <= ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          led.led_index <= pklft_pkg::KEY_IDX_W'(key);
          led.red <= lit ? quot_red : inactive_red;
          led.green <= lit ? quot_green : inactive_green;
          led.blue <= lit ? quot_blue : inactive_blue;
          led.last_of_frame <= last_key;
          led_valid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (led_ready) begin
            led_valid <= 1'b0;
            if (last_key) begin
              state <= ST_IDLE;
            end else begin
              key <= key + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The block never offers a result while it can take a command.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(led_valid && cmd_ready))
    else $error("result offered while commands are taken");

  // The final result of a step returns the block to idle.
  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (led_valid && led_ready && led.last_of_frame) |=> cmd_ready)
    else $error("walk did not end after the last key");

  // Any other result keeps the walk going.
  a_mid_continues: assert property (@(posedge clk) disable iff (rst)
    (led_valid && led_ready && !led.last_of_frame) |=> !cmd_ready)
    else $error("walk ended before the last key");

  // Elapsed time is cleared once a step starts.
  a_elapsed_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (elapsed_ms == '0))
    else $error("elapsed time not cleared during a step");

endmodule
